@@ src/page_frame_free_list_allocator_assert.svh @@
// -----------------------------------------------------------------------------
// Page frame allocator assertion macros
// Concurrent checks clocked on i_clk, held off during reset.
// -----------------------------------------------------------------------------
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Invariant that holds at every edge.
`define PFA_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define PFA_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define PFA_ASSERT(lbl, expr, msg)
`define PFA_ASSERT_NEXT(lbl, cond, expr, msg)
`endif

`endif

@@ src/pfa_pkg.sv @@
// -----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and memory request types of the frame allocator.
// -----------------------------------------------------------------------------
package pfa_pkg;

    localparam int FRAMES     = 128;
    localparam int FRAME_W    = $clog2(FRAMES);
    localparam int OWNER_BITS = 8;
    localparam int COUNT_W    = $clog2(FRAMES + 1);

    localparam logic [1:0] CMD_ALLOC      = 2'd0;
    localparam logic [1:0] CMD_FREE       = 2'd1;
    localparam logic [1:0] CMD_FREE_OWNER = 2'd2;

    localparam logic [1:0] STAT_OK           = 2'd0;
    localparam logic [1:0] STAT_NO_FREE      = 2'd1;
    localparam logic [1:0] STAT_ALREADY_FREE = 2'd2;

    typedef struct packed {
        logic                  rd_en;
        logic [FRAME_W-1:0]    rd_addr;
        logic                  wr_en;
        logic [FRAME_W-1:0]    wr_addr;
        logic [OWNER_BITS-1:0] wr_data;
    } t_own_req;

    typedef struct packed {
        logic               rd_en;
        logic [FRAME_W-1:0] rd_addr;
        logic               wr_en;
        logic [FRAME_W-1:0] wr_addr;
        logic [FRAME_W-1:0] wr_data;
    } t_ring_req;

    // Advance a ring pointer with wrap at FRAMES.
    function automatic logic [FRAME_W-1:0] next_ptr(input logic [FRAME_W-1:0] ptr);
        logic [FRAME_W-1:0] res;
        if (ptr == FRAME_W'(FRAMES - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

endpackage

@@ src/page_frame_free_list_allocator.sv @@
// -----------------------------------------------------------------------------
// page_frame_free_list_allocator
// Allocate or free one frame: table reads start at accept, and the result is
// registered once the output register is free. Free all of an owner: one owner
// table entry per cycle through its single read port, the last one held until
// the output register is free. Not ready while an item is at work; a result
// waiting in the output register does not block the next accept. Synchronous
// active-low reset; owner table reads cleared, free ring ascending, no sweep.
// -----------------------------------------------------------------------------
module page_frame_free_list_allocator
    import pfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_cmd,
    input  logic [OWNER_BITS-1:0] i_owner_id,
    input  logic [5:0]            i_page_num,
    input  logic [FRAME_W-1:0]    i_frame_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic [FRAME_W-1:0]    o_frame,
    output logic [5:0]            o_page_echo,
    output logic [COUNT_W-1:0]    o_freed_count,
    output logic [COUNT_W-1:0]    o_free_frames,
    output logic [COUNT_W-1:0]    o_used_frames
);

`include "page_frame_free_list_allocator_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state                r_state,   n_state;
    logic [1:0]            r_cmd,     n_cmd;
    logic [OWNER_BITS-1:0] r_owner,   n_owner;
    logic [5:0]            r_page,    n_page;
    logic [FRAME_W-1:0]    r_fidx,    n_fidx;
    logic [FRAME_W-1:0]    r_idx,     n_idx;
    logic [COUNT_W-1:0]    r_freed,   n_freed;
    logic [FRAME_W-1:0]    r_head,    n_head;
    logic [FRAME_W-1:0]    r_tail,    n_tail;
    logic [COUNT_W-1:0]    r_free_total, n_free_total;
    logic [COUNT_W-1:0]    r_used_total, n_used_total;
    logic                  r_o_valid, n_o_valid;
    logic [1:0]            r_o_status, n_o_status;
    logic [FRAME_W-1:0]    r_o_frame, n_o_frame;
    logic [5:0]            r_o_page,  n_o_page;
    logic [COUNT_W-1:0]    r_o_freed, n_o_freed;
    logic [COUNT_W-1:0]    r_o_free,  n_o_free;
    logic [COUNT_W-1:0]    r_o_used,  n_o_used;

    t_own_req              own_req;
    t_ring_req             ring_req;
    logic [OWNER_BITS-1:0] own_rd;
    logic [FRAME_W-1:0]    ring_rd;
    logic                  out_free;
    logic                  last_idx;
    logic                  match;
    logic                  fidx_bad;

    pfa_owner_mem u_owner (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (own_req),
        .o_rd_data (own_rd)
    );

    pfa_ring_mem u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ring_req),
        .o_rd_data (ring_rd)
    );

    assign out_free = !r_o_valid || i_ready;
    assign last_idx = (r_idx == FRAME_W'(FRAMES - 1));
    assign match    = (r_owner != '0) && (own_rd == r_owner);
    assign fidx_bad = (int'(r_fidx) >= FRAMES);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_owner      = r_owner;
        n_page       = r_page;
        n_fidx       = r_fidx;
        n_idx        = r_idx;
        n_freed      = r_freed;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free_total = r_free_total;
        n_used_total = r_used_total;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_status   = r_o_status;
        n_o_frame    = r_o_frame;
        n_o_page     = r_o_page;
        n_o_freed    = r_o_freed;
        n_o_free     = r_o_free;
        n_o_used     = r_o_used;
        own_req      = '0;
        ring_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_owner = i_owner_id;
                    n_page  = i_page_num;
                    n_fidx  = i_frame_index;
                    n_idx   = '0;
                    n_freed = '0;
                    n_state = (i_cmd == CMD_FREE_OWNER) ? S_SCAN : S_EXEC;
                    // Start the table read for the first cycle of work.
                    own_req.rd_en    = 1'b1;
                    own_req.rd_addr  = (i_cmd == CMD_FREE) ? i_frame_index : '0;
                    ring_req.rd_en   = 1'b1;
                    ring_req.rd_addr = r_head;
                end
            end
            S_EXEC: begin
                // Hold until the output register can take the item.
                if (out_free) begin
                    n_o_status = STAT_OK;
                    n_o_frame  = '0;
                    n_o_freed  = '0;
                    case (r_cmd)
                        CMD_ALLOC: begin
                            if (r_free_total == '0 || r_owner == '0) begin
                                n_o_status = STAT_NO_FREE;
                            end else begin
                                n_o_frame       = ring_rd;
                                n_head          = next_ptr(r_head);
                                own_req.wr_en   = 1'b1;
                                own_req.wr_addr = ring_rd;
                                own_req.wr_data = r_owner;
                                n_free_total    = r_free_total - 1'b1;
                                n_used_total    = r_used_total + 1'b1;
                            end
                        end
                        CMD_FREE: begin
                            n_o_frame = r_fidx;
                            if (fidx_bad || own_rd == '0) begin
                                n_o_status = STAT_ALREADY_FREE;
                            end else begin
                                own_req.wr_en    = 1'b1;
                                own_req.wr_addr  = r_fidx;
                                own_req.wr_data  = '0;
                                ring_req.wr_en   = 1'b1;
                                ring_req.wr_addr = r_tail;
                                ring_req.wr_data = r_fidx;
                                n_tail           = next_ptr(r_tail);
                                n_free_total     = r_free_total + 1'b1;
                                n_used_total     = r_used_total - 1'b1;
                                n_o_freed        = COUNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_o_valid = 1'b1;
                    n_o_page  = r_page;
                    n_o_free  = n_free_total;
                    n_o_used  = n_used_total;
                    n_state   = S_IDLE;
                end
            end
            S_SCAN: begin
                // Stall only the final frame until the output slot is free.
                if (!last_idx || out_free) begin
                    if (match) begin
                        own_req.wr_en    = 1'b1;
                        own_req.wr_addr  = r_idx;
                        own_req.wr_data  = '0;
                        ring_req.wr_en   = 1'b1;
                        ring_req.wr_addr = r_tail;
                        ring_req.wr_data = r_idx;
                        n_tail           = next_ptr(r_tail);
                        n_free_total     = r_free_total + 1'b1;
                        n_used_total     = r_used_total - 1'b1;
                        n_freed          = r_freed + 1'b1;
                    end
                    if (!last_idx) begin
                        own_req.rd_en   = 1'b1;
                        own_req.rd_addr = r_idx + 1'b1;
                        n_idx           = r_idx + 1'b1;
                    end else begin
                        n_o_valid  = 1'b1;
                        n_o_status = STAT_OK;
                        n_o_frame  = '0;
                        n_o_page   = r_page;
                        n_o_freed  = n_freed;
                        n_o_free   = n_free_total;
                        n_o_used   = n_used_total;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_free_total <= COUNT_W'(FRAMES);
            r_used_total <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_free_total <= n_free_total;
            r_used_total <= n_used_total;
            r_o_valid    <= n_o_valid;
        end
        r_cmd      <= n_cmd;
        r_owner    <= n_owner;
        r_page     <= n_page;
        r_fidx     <= n_fidx;
        r_idx      <= n_idx;
        r_freed    <= n_freed;
        r_o_status <= n_o_status;
        r_o_frame  <= n_o_frame;
        r_o_page   <= n_o_page;
        r_o_freed  <= n_o_freed;
        r_o_free   <= n_o_free;
        r_o_used   <= n_o_used;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_frame       = r_o_frame;
    assign o_page_echo   = r_o_page;
    assign o_freed_count = r_o_freed;
    assign o_free_frames = r_o_free;
    assign o_used_frames = r_o_used;

    `PFA_ASSERT(a_frame_conservation, (r_free_total + r_used_total) == COUNT_W'(FRAMES), "free plus used frames differ from FRAMES")
    `PFA_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready after accepting an item")
    `PFA_ASSERT_NEXT(a_scan_never_allocates, r_state == S_SCAN, r_free_total >= $past(r_free_total), "free count dropped during owner scan")

endmodule

@@ src/pfa_owner_mem.sv @@
// -----------------------------------------------------------------------------
// pfa_owner_mem
// Owner table: one owner code per frame, with per-entry written bits so
// unwritten entries read as empty right after reset.
// -----------------------------------------------------------------------------
module pfa_owner_mem
    import pfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_own_req              i_req,
    output logic [OWNER_BITS-1:0] o_rd_data
);

    logic [OWNER_BITS-1:0] r_mem [FRAMES];
    logic [FRAMES-1:0]     r_vld;
    logic [OWNER_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    // Unwritten entries read as empty.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_vld[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/pfa_ring_mem.sv @@
// -----------------------------------------------------------------------------
// pfa_ring_mem
// Free ring storage: frame numbers in FIFO order; an unwritten entry reads
// as its own index, the ascending order after reset.
// -----------------------------------------------------------------------------
module pfa_ring_mem
    import pfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ring_req          i_req,
    output logic [FRAME_W-1:0] o_rd_data
);

    logic [FRAME_W-1:0] r_mem [FRAMES];
    logic [FRAMES-1:0]  r_vld;
    logic [FRAME_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_vld[i_req.rd_addr] ? r_mem[i_req.rd_addr] : i_req.rd_addr;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives allocate, free and free-by-owner commands through the valid/ready
// input; checks each result against its hand-written value or a frame-level
// model of the free ring and owner table. A directed script comes first, then
// random traffic in phases: no idling, idle sender, stalling receiver, both.
// -----------------------------------------------------------------------------
module tb;
    import pfa_pkg::*;

    localparam logic [1:0] CMD_NOP   = 2'd3;
    localparam int         CYCLE_CAP = 1000000;
    localparam int         DRAIN     = 150;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
        logic [5:0]         page;
        logic [COUNT_W-1:0] freed;
        logic [COUNT_W-1:0] free_frames;
        logic [COUNT_W-1:0] used_frames;
    } t_alloc_result;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [OWNER_BITS-1:0] owner;
        logic [5:0]            page;
        logic [FRAME_W-1:0]    fidx;
        logic [8:0]            reps;
        bit                    typed;
        t_alloc_result         want;
    } t_script_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_cmd         = CMD_NOP;
    logic [OWNER_BITS-1:0] i_owner_id    = '0;
    logic [5:0]            i_page_num    = '0;
    logic [FRAME_W-1:0]    i_frame_index = '0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [1:0]            o_status;
    logic [FRAME_W-1:0]    o_frame;
    logic [5:0]            o_page_echo;
    logic [COUNT_W-1:0]    o_freed_count;
    logic [COUNT_W-1:0]    o_free_frames;
    logic [COUNT_W-1:0]    o_used_frames;

    // Model of the allocator
    logic [OWNER_BITS-1:0] owner_tab [FRAMES];
    logic [FRAME_W-1:0]    free_ring [FRAMES];
    logic [FRAME_W-1:0]    ring_head;
    logic [FRAME_W-1:0]    ring_tail;
    logic [COUNT_W-1:0]    free_cnt;
    logic [COUNT_W-1:0]    used_cnt;

    t_alloc_result pending_results [$];
    int            mismatches    = 0;
    int            cycle_count   = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    // Directed script; rows with typed set carry a hand-written result
    t_script_row script [0:16] = '{
        '{CMD_ALLOC, 8'd1, 6'd0, 7'd0, 9'd1, 1'b1,
          '{STAT_OK, 7'd0, 6'd0, 8'd0, 8'd127, 8'd1}},
        '{CMD_ALLOC, 8'd255, 6'd63, 7'd127, 9'd1, 1'b1,
          '{STAT_OK, 7'd1, 6'd63, 8'd0, 8'd126, 8'd2}},
        '{CMD_ALLOC, 8'd0, 6'd5, 7'd0, 9'd1, 1'b1,
          '{STAT_NO_FREE, 7'd0, 6'd5, 8'd0, 8'd126, 8'd2}},
        '{CMD_FREE, 8'd7, 6'd9, 7'd0, 9'd1, 1'b1,
          '{STAT_OK, 7'd0, 6'd9, 8'd1, 8'd127, 8'd1}},
        '{CMD_FREE, 8'd7, 6'd10, 7'd0, 9'd1, 1'b1,
          '{STAT_ALREADY_FREE, 7'd0, 6'd10, 8'd0, 8'd127, 8'd1}},
        '{CMD_FREE, 8'd0, 6'd11, 7'd127, 9'd1, 1'b1,
          '{STAT_ALREADY_FREE, 7'd127, 6'd11, 8'd0, 8'd127, 8'd1}},
        '{CMD_FREE_OWNER, 8'd0, 6'd12, 7'd0, 9'd1, 1'b1,
          '{STAT_OK, 7'd0, 6'd12, 8'd0, 8'd127, 8'd1}},
        '{CMD_NOP, 8'd255, 6'd63, 7'd127, 9'd1, 1'b1,
          '{STAT_OK, 7'd0, 6'd63, 8'd0, 8'd127, 8'd1}},
        '{CMD_FREE_OWNER, 8'd255, 6'd13, 7'd0, 9'd1, 1'b1,
          '{STAT_OK, 7'd0, 6'd13, 8'd1, 8'd128, 8'd0}},
        '{CMD_ALLOC, 8'd3, 6'd20, 7'd0, 9'd128, 1'b0, '0},
        '{CMD_ALLOC, 8'd4, 6'd21, 7'd0, 9'd1, 1'b1,
          '{STAT_NO_FREE, 7'd0, 6'd21, 8'd0, 8'd0, 8'd128}},
        '{CMD_FREE, 8'd0, 6'd22, 7'd64, 9'd1, 1'b1,
          '{STAT_OK, 7'd64, 6'd22, 8'd1, 8'd1, 8'd127}},
        '{CMD_ALLOC, 8'd5, 6'd23, 7'd0, 9'd1, 1'b0, '0},
        '{CMD_FREE_OWNER, 8'd3, 6'd24, 7'd0, 9'd1, 1'b1,
          '{STAT_OK, 7'd0, 6'd24, 8'd127, 8'd127, 8'd1}},
        '{CMD_FREE_OWNER, 8'd5, 6'd25, 7'd0, 9'd1, 1'b1,
          '{STAT_OK, 7'd0, 6'd25, 8'd1, 8'd128, 8'd0}},
        '{CMD_ALLOC, 8'h80, 6'h2A, 7'h55, 9'd128, 1'b0, '0},
        '{CMD_FREE_OWNER, 8'h80, 6'd26, 7'd0, 9'd1, 1'b1,
          '{STAT_OK, 7'd0, 6'd26, 8'd128, 8'd128, 8'd0}}
    };

    page_frame_free_list_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_owner_id    (i_owner_id),
        .i_page_num    (i_page_num),
        .i_frame_index (i_frame_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_frame       (o_frame),
        .o_page_echo   (o_page_echo),
        .o_freed_count (o_freed_count),
        .o_free_frames (o_free_frames),
        .o_used_frames (o_used_frames)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Append a frame to the tail of the free ring
    function automatic void release_frame(input logic [FRAME_W-1:0] frame);
        free_ring[ring_tail] = frame;
        ring_tail = (ring_tail == FRAME_W'(FRAMES - 1)) ? '0 : ring_tail + 1'b1;
        free_cnt = free_cnt + 1'b1;
        used_cnt = used_cnt - 1'b1;
    endfunction

    function automatic t_alloc_result apply_command(
        input logic [1:0]            cmd,
        input logic [OWNER_BITS-1:0] owner,
        input logic [5:0]            page,
        input logic [FRAME_W-1:0]    fidx
    );
        t_alloc_result res;
        res = '0;
        res.page = page;
        case (cmd)
            CMD_ALLOC: begin
                if (free_cnt == 0 || owner == 0) begin
                    res.status = STAT_NO_FREE;
                end else begin
                    res.frame = free_ring[ring_head];
                    ring_head = (ring_head == FRAME_W'(FRAMES - 1)) ? '0 : ring_head + 1'b1;
                    owner_tab[res.frame] = owner;
                    free_cnt = free_cnt - 1'b1;
                    used_cnt = used_cnt + 1'b1;
                end
            end
            CMD_FREE: begin
                res.frame = fidx;
                if (owner_tab[fidx] == 0) begin
                    res.status = STAT_ALREADY_FREE;
                end else begin
                    owner_tab[fidx] = '0;
                    release_frame(fidx);
                    res.freed = COUNT_W'(1);
                end
            end
            CMD_FREE_OWNER: begin
                if (owner != 0) begin
                    for (int n = 0; n < FRAMES; n++) begin
                        if (owner_tab[n] == owner) begin
                            owner_tab[n] = '0;
                            release_frame(FRAME_W'(n));
                            res.freed = res.freed + 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.free_frames = free_cnt;
        res.used_frames = used_cnt;
        return res;
    endfunction

    // Random frame that currently holds a page, or -1 if none does
    function automatic int find_used_frame();
        int start;
        int idx;
        start = $urandom_range(FRAMES - 1);
        for (int n = 0; n < FRAMES; n++) begin
            idx = (start + n) % FRAMES;
            if (owner_tab[idx] != 0) begin
                return idx;
            end
        end
        return -1;
    endfunction

    // Entered and left at a falling edge
    task automatic issue_command(
        input logic [1:0]            cmd,
        input logic [OWNER_BITS-1:0] owner,
        input logic [5:0]            page,
        input logic [FRAME_W-1:0]    fidx,
        input bit                    typed,
        input t_alloc_result         want
    );
        t_alloc_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_owner_id    <= owner;
        i_page_num    <= page;
        i_frame_index <= fidx;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predicted = apply_command(cmd, owner, page, fidx);
        if (typed) begin
            predicted = want;
        end
        pending_results = {pending_results, predicted};
        @(negedge i_clk);
    endtask

    task automatic issue_random(input int alloc_pct);
        int                    r;
        int                    f;
        logic [1:0]            cmd;
        logic [OWNER_BITS-1:0] owner;
        logic [FRAME_W-1:0]    fidx;
        r = $urandom_range(99);
        // Mostly a small owner pool so that free-by-owner releases real frames
        owner = ($urandom_range(9) < 7) ? OWNER_BITS'($urandom_range(6, 1))
                                        : OWNER_BITS'($urandom_range(255, 1));
        fidx = FRAME_W'($urandom_range(FRAMES - 1));
        if (r < alloc_pct) begin
            cmd = CMD_ALLOC;
            if ($urandom_range(39) == 0) begin
                owner = '0;
            end
        end else if (r >= 98) begin
            cmd = CMD_NOP;
        end else if (r >= 92) begin
            cmd = CMD_FREE_OWNER;
            if ($urandom_range(9) == 0) begin
                owner = '0;
            end
        end else begin
            cmd = CMD_FREE;
            if ($urandom_range(4) != 0) begin
                f = find_used_frame();
                if (f >= 0) begin
                    fidx = FRAME_W'(f);
                end
            end
        end
        issue_command(cmd, owner, 6'($urandom_range(63)), fidx, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_alloc_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no command outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("frame", want.frame, o_frame);
                check_field("page_echo", want.page, o_page_echo);
                check_field("freed_count", want.freed, o_freed_count);
                check_field("free_frames", want.free_frames, o_free_frames);
                check_field("used_frames", want.used_frames, o_used_frames);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        for (int n = 0; n < FRAMES; n++) begin
            owner_tab[n] = '0;
            free_ring[n] = FRAME_W'(n);
        end
        ring_head = '0;
        ring_tail = '0;
        free_cnt  = COUNT_W'(FRAMES);
        used_cnt  = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[row]) begin
            repeat (script[row].reps) begin
                issue_command(script[row].cmd, script[row].owner, script[row].page,
                              script[row].fidx, script[row].typed, script[row].want);
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            // Vary the allocate share so the ring both drains and fills up
            for (int chunk = 0; chunk < 5; chunk++) begin
                int alloc_pct;
                alloc_pct = $urandom_range(82, 35);
                repeat (81) issue_random(alloc_pct);
            end
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ page_frame_free_list_allocator.f @@
+incdir+src
src/pfa_pkg.sv
src/pfa_owner_mem.sv
src/pfa_ring_mem.sv
src/page_frame_free_list_allocator.sv
test/tb.sv
